@@ src/ltd_pkg.sv @@
// ============================================================================
// ltd_pkg
// Shared types and constants of the LFSR timestamp hit decoder.
// ============================================================================
package ltd_pkg;

  localparam int unsigned LFSR_BITS    = 15;
  localparam int unsigned DEC_W        = 16;
  localparam int unsigned CHAN_W       = 15;
  localparam int unsigned SLOT_W       = 7;
  localparam int unsigned WCNT_W       = 17;
  localparam int unsigned CHAN_LO_W    = 10;
  localparam int unsigned CHAN_HI_N    = 32;
  localparam int unsigned CHANNELS_DEF = 32768;

  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MODE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LIMIT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_WORDS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SIZE   = 8'd3;

  localparam logic [1:0] MODE_ECC = 2'd0;
  localparam logic [1:0] MODE_TCC = 2'd1;

  localparam logic [1:0]  MODE_RST   = 2'd2;
  localparam logic [15:0] LIMIT_RST  = 16'd1000;
  localparam logic [15:0] WARMUP_RST = 16'd2000;
  localparam logic [7:0]  BATCH_RST  = 8'd100;
  localparam logic [7:0]  BATCH_MAX  = 8'd128;

  localparam logic [DEC_W-1:0] DIFF_BIAS = 16'd32767;

  typedef struct packed {
    logic                 busy;
    logic [LFSR_BITS-1:0] idx;
  } sweep_t;

  typedef struct packed {
    logic              is_reset_event;
    logic              hit_accepted;
    logic [CHAN_W-1:0] channel_index;
    logic [DEC_W-1:0]  decoded_value;
    logic [SLOT_W-1:0] slot_index;
    logic              batch_complete;
  } result_t;

endpackage

@@ src/ltd_if.sv @@
// ============================================================================
// ltd_if
// Valid/ready channels of the hit decoder: input word, result, configuration.
// ============================================================================
interface ltd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;
  logic [7:0] byte6;
  logic [7:0] byte7;

  modport source (output valid, byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
                  input ready);
  modport sink   (input valid, byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
                  output ready);
endinterface

interface ltd_out_if;
  logic                           valid;
  logic                           ready;
  logic                           is_reset_event;
  logic                           hit_accepted;
  logic [ltd_pkg::CHAN_W-1:0]     channel_index;
  logic [ltd_pkg::DEC_W-1:0]      decoded_value;
  logic [ltd_pkg::SLOT_W-1:0]     slot_index;
  logic                           batch_complete;

  modport source (output valid, is_reset_event, hit_accepted, channel_index, decoded_value,
                  slot_index, batch_complete, input ready);
  modport sink   (input valid, is_reset_event, hit_accepted, channel_index, decoded_value,
                  slot_index, batch_complete, output ready);
endinterface

interface ltd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ltd_pkg::CFG_IDX_W-1:0]  index;
  logic [ltd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/ltd_decode_table.sv @@
// ============================================================================
// ltd_decode_table
// LFSR state to count decode memory with two read ports. After reset a sweep
// runs the LFSR and writes one entry per cycle until the table is complete.
// ============================================================================
module ltd_decode_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rd_en,
  input  logic [ltd_pkg::LFSR_BITS-1:0]   rd_addr_a,
  input  logic [ltd_pkg::LFSR_BITS-1:0]   rd_addr_b,
  output logic [ltd_pkg::DEC_W-1:0]       rd_data_a,
  output logic [ltd_pkg::DEC_W-1:0]       rd_data_b,
  output ltd_pkg::sweep_t                 sweep
);

  localparam int unsigned DEPTH = 1 << ltd_pkg::LFSR_BITS;

  logic [ltd_pkg::DEC_W-1:0]     mem [DEPTH];
  logic [ltd_pkg::DEC_W-1:0]     rd_a_r;
  logic [ltd_pkg::DEC_W-1:0]     rd_b_r;
  logic                          busy_r;
  logic [ltd_pkg::LFSR_BITS-1:0] idx_r;
  logic [ltd_pkg::LFSR_BITS-1:0] lfsr_r;
  logic [ltd_pkg::LFSR_BITS-1:0] lfsr_nxt;
  logic                          last;
  logic [ltd_pkg::LFSR_BITS-1:0] wr_addr;
  logic [ltd_pkg::DEC_W-1:0]     wr_data;

  // The all-ones state never occurs in the sequence and decodes to all ones.
  assign last     = (idx_r == '1);
  assign lfsr_nxt = {lfsr_r[ltd_pkg::LFSR_BITS-2:0],
                     ~(lfsr_r[ltd_pkg::LFSR_BITS-2] ^ lfsr_r[ltd_pkg::LFSR_BITS-1])};
  assign wr_addr  = last ? '1 : lfsr_r;
  assign wr_data  = last ? '1 : {1'b0, idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      lfsr_r <= '0;
    end else if (busy_r) begin
      idx_r  <= idx_r + 1'b1;
      lfsr_r <= lfsr_nxt;
      if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a  = rd_a_r;
  assign rd_data_b  = rd_b_r;
  assign sweep.busy = busy_r;
  assign sweep.idx  = idx_r;

endmodule

@@ src/lfsr_timestamp_hit_decoder_top.sv @@
// ============================================================================
// lfsr_timestamp_hit_decoder_top
// Decodes detector hit words into channel, value, slot and batch status.
// ============================================================================
// The block takes one readout word per cycle while the output is not stalled
// and returns one result word per input word, through the p1, p2 and output
// registers. The pipeline reads the two coarse counters from a dual-read
// decode memory, forms the selected value, and then updates the per-channel
// slot counter in a memory with one read and one write port by
// read-modify-write with forwarding of the previous write. After reset the
// block builds the decode table and clears the slot memory in one pass,
// during which no input word is taken; configuration writes are taken at any time.
module lfsr_timestamp_hit_decoder_top #(
  parameter int unsigned CHANNELS = ltd_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ltd_in_if.sink      in_ch,
  ltd_out_if.source   out_ch,
  ltd_cfg_if.sink     cfg_ch
);

  localparam int unsigned AW = $clog2(CHANNELS);

  logic [1:0]  mode_r;
  logic [15:0] limit_r;
  logic [15:0] warmup_r;
  logic [7:0]  batch_r;

  logic [ltd_pkg::WCNT_W-1:0] wcnt_r;
  logic [ltd_pkg::WCNT_W-1:0] wcnt_nxt;

  ltd_pkg::sweep_t               sweep;
  logic [ltd_pkg::DEC_W-1:0]     ecc;
  logic [ltd_pkg::DEC_W-1:0]     tcc;
  logic [ltd_pkg::LFSR_BITS-1:0] ecc_idx;
  logic [ltd_pkg::LFSR_BITS-1:0] tcc_idx;

  logic                        en;
  logic                        accept;
  logic                        is_rst;
  logic [ltd_pkg::CHAN_W-1:0]  chan;
  logic [AW-1:0]               base_tab [ltd_pkg::CHAN_HI_N];
  logic [AW:0]                 addr_sum;
  logic [AW-1:0]               slot_addr;

  logic                        p1_valid_r;
  logic                        p1_rst_r;
  logic                        p1_warm_r;
  logic [ltd_pkg::CHAN_W-1:0]  p1_chan_r;
  logic [AW-1:0]               p1_addr_r;
  logic [ltd_pkg::DEC_W-1:0]   val;

  logic                        p2_valid_r;
  logic                        p2_rst_r;
  logic                        p2_acc_r;
  logic [ltd_pkg::CHAN_W-1:0]  p2_chan_r;
  logic [AW-1:0]               p2_addr_r;
  logic [ltd_pkg::DEC_W-1:0]   p2_val_r;

  logic [ltd_pkg::SLOT_W-1:0]  slot_mem [CHANNELS];
  logic [ltd_pkg::SLOT_W-1:0]  slot_rd_r;
  logic                        wb_valid_r;
  logic [AW-1:0]               wb_addr_r;
  logic [ltd_pkg::SLOT_W-1:0]  wb_data_r;
  logic [ltd_pkg::SLOT_W-1:0]  cnt;
  logic [7:0]                  bs;
  logic [7:0]                  cnt_inc;
  logic                        complete;
  logic [ltd_pkg::SLOT_W-1:0]  cnt_nxt;
  logic                        slot_we;
  logic [AW-1:0]               slot_waddr;
  logic [ltd_pkg::SLOT_W-1:0]  slot_wdata;

  logic                        out_valid_r;
  ltd_pkg::result_t            out_r;
  ltd_pkg::result_t            out_nxt;

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ltd_pkg::MODE_RST;
      limit_r  <= ltd_pkg::LIMIT_RST;
      warmup_r <= ltd_pkg::WARMUP_RST;
      batch_r  <= ltd_pkg::BATCH_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        ltd_pkg::CFG_VALUE_MODE:   mode_r   <= cfg_ch.data[1:0];
        ltd_pkg::CFG_VALUE_LIMIT:  limit_r  <= cfg_ch.data;
        ltd_pkg::CFG_WARMUP_WORDS: warmup_r <= cfg_ch.data;
        ltd_pkg::CFG_BATCH_SIZE:   batch_r  <= cfg_ch.data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input stage.
  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en && !sweep.busy;
  assign accept       = in_ch.valid && in_ch.ready;

  assign ecc_idx = {in_ch.byte1[3:0], in_ch.byte2, in_ch.byte3[7:5]};
  assign tcc_idx = {in_ch.byte6[0], in_ch.byte7, in_ch.byte0[7:2]};
  assign chan    = {in_ch.byte4[6:2], in_ch.byte4[1:0], in_ch.byte5[7:6], in_ch.byte6[7:2]};
  assign is_rst  = (in_ch.byte5 == 8'hFF) && (in_ch.byte6 == 8'hFF) &&
                   (in_ch.byte7 == 8'hFF) && (in_ch.byte0[7:2] == 6'h3F);

  assign wcnt_nxt = (wcnt_r != '1) ? wcnt_r + 1'b1 : wcnt_r;

  // The channel is split into a high part, reduced through a table of
  // residues, and a low part below the channel count.
  for (genvar g = 0; g < ltd_pkg::CHAN_HI_N; g++) begin : g_base
    localparam int unsigned BASE = (g * (1 << ltd_pkg::CHAN_LO_W)) % CHANNELS;
    assign base_tab[g] = AW'(BASE);
  end

  assign addr_sum  = (AW+1)'(base_tab[chan[ltd_pkg::CHAN_W-1:ltd_pkg::CHAN_LO_W]]) +
                     (AW+1)'(chan[ltd_pkg::CHAN_LO_W-1:0]);
  assign slot_addr = (32'(addr_sum) >= CHANNELS) ? AW'(32'(addr_sum) - CHANNELS)
                                                 : addr_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r <= '0;
    end else if (accept) begin
      wcnt_r <= wcnt_nxt;
    end
  end

  ltd_decode_table u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (en),
    .rd_addr_a (ecc_idx),
    .rd_addr_b (tcc_idx),
    .rd_data_a (ecc),
    .rd_data_b (tcc),
    .sweep     (sweep)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_rst_r  <= is_rst;
      p1_warm_r <= (wcnt_nxt > {1'b0, warmup_r});
      p1_chan_r <= chan;
      p1_addr_r <= slot_addr;
    end
  end

  // Value stage.
  always_comb begin
    unique case (mode_r)
      ltd_pkg::MODE_ECC: val = ecc;
      ltd_pkg::MODE_TCC: val = tcc;
      default: begin
        if (ecc > tcc) begin
          val = ecc - tcc;
        end else begin
          val = ltd_pkg::DIFF_BIAS + ecc - tcc;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (en) begin
      p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_rst_r  <= p1_rst_r;
      p2_acc_r  <= !p1_rst_r && p1_warm_r && (val < limit_r);
      p2_chan_r <= p1_chan_r;
      p2_addr_r <= p1_addr_r;
      p2_val_r  <= val;
    end
  end

  // Slot update stage. The read issued by this word saw memory before the
  // write of the word ahead of it, so that write is forwarded.
  assign cnt      = (wb_valid_r && (wb_addr_r == p2_addr_r)) ? wb_data_r : slot_rd_r;
  assign bs       = (batch_r == 8'd0) ? 8'd1 :
                    ((batch_r > ltd_pkg::BATCH_MAX) ? ltd_pkg::BATCH_MAX : batch_r);
  assign cnt_inc  = {1'b0, cnt} + 8'd1;
  assign complete = (cnt_inc >= bs);
  assign cnt_nxt  = complete ? '0 : cnt_inc[ltd_pkg::SLOT_W-1:0];

  always_comb begin
    if (sweep.busy) begin
      slot_we    = (32'(sweep.idx) < CHANNELS);
      slot_waddr = sweep.idx[AW-1:0];
      slot_wdata = '0;
    end else begin
      slot_we    = en && p2_valid_r && p2_acc_r;
      slot_waddr = p2_addr_r;
      slot_wdata = cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (en) begin
      slot_rd_r <= slot_mem[p1_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else if (en) begin
      wb_valid_r <= p2_valid_r && p2_acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wb_addr_r <= p2_addr_r;
      wb_data_r <= cnt_nxt;
    end
  end

  // Output register.
  always_comb begin
    out_nxt                = '0;
    out_nxt.is_reset_event = p2_rst_r;
    if (!p2_rst_r) begin
      out_nxt.channel_index = p2_chan_r;
      out_nxt.decoded_value = p2_val_r;
      if (p2_acc_r) begin
        out_nxt.hit_accepted   = 1'b1;
        out_nxt.slot_index     = cnt;
        out_nxt.batch_complete = complete;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.is_reset_event = out_r.is_reset_event;
  assign out_ch.hit_accepted   = out_r.hit_accepted;
  assign out_ch.channel_index  = out_r.channel_index;
  assign out_ch.decoded_value  = out_r.decoded_value;
  assign out_ch.slot_index     = out_r.slot_index;
  assign out_ch.batch_complete = out_r.batch_complete;

endmodule
